FILE: rtl/epg_pkg.sv
// Shared types and constants of the ellipse point generator.
// Holds request and result structs, register indexes and the CORDIC angle table.
// Depends on nothing; every other file imports it.
package epg_pkg;

    typedef struct packed {
        logic        action;
        logic [15:0] phase_turns;
    } in_req_t;

    typedef struct packed {
        logic signed [23:0] x_coord;
        logic signed [23:0] y_coord;
    } out_res_t;

    // Request actions.
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_DIRECT  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_CENTER_X    = 3'd0;
    localparam logic [2:0] REG_CENTER_Y    = 3'd1;
    localparam logic [2:0] REG_RADIUS_X    = 3'd2;
    localparam logic [2:0] REG_RADIUS_Y    = 3'd3;
    localparam logic [2:0] REG_STEPS_COUNT = 3'd4;
    localparam logic [2:0] REG_STRIDE      = 3'd5;

    // Register values after reset.
    localparam logic [23:0] CENTER_X_RST = 24'd16384;
    localparam logic [23:0] CENTER_Y_RST = 24'd16384;
    localparam logic [23:0] RADIUS_X_RST = 24'd8192;
    localparam logic [23:0] RADIUS_Y_RST = 24'd5632;
    localparam logic [31:0] STRIDE_RST   = 32'd65536;

    // Smallest accepted revolution length and its replacement value.
    localparam logic [31:0] STEPS_MIN     = 32'd6554;
    localparam logic [31:0] STEPS_DEFAULT = 32'd6553600;

    // Output coordinate limits.
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // The divider produces one quotient bit per cycle of a 48-bit dividend.
    localparam int DIV_BITS = 48;

    // CORDIC rotation count and start gain at a scale of 2^30.
    localparam int          CORDIC_ITERS = 30;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'h20000000;
            5'd1:    val = 30'h12E4051E;
            5'd2:    val = 30'h09FB385B;
            5'd3:    val = 30'h051111D4;
            5'd4:    val = 30'h028B0D43;
            5'd5:    val = 30'h0145D7E1;
            5'd6:    val = 30'h00A2F61E;
            5'd7:    val = 30'h00517C55;
            5'd8:    val = 30'h0028BE53;
            5'd9:    val = 30'h00145F2F;
            5'd10:   val = 30'h000A2F98;
            5'd11:   val = 30'h000517CC;
            5'd12:   val = 30'h00028BE6;
            5'd13:   val = 30'h000145F3;
            5'd14:   val = 30'h0000A2FA;
            5'd15:   val = 30'h0000517D;
            5'd16:   val = 30'h000028BE;
            5'd17:   val = 30'h0000145F;
            5'd18:   val = 30'h00000A30;
            5'd19:   val = 30'h00000518;
            5'd20:   val = 30'h0000028C;
            5'd21:   val = 30'h00000146;
            5'd22:   val = 30'h000000A3;
            5'd23:   val = 30'h00000051;
            5'd24:   val = 30'h00000029;
            5'd25:   val = 30'h00000014;
            5'd26:   val = 30'h0000000A;
            5'd27:   val = 30'h00000005;
            5'd28:   val = 30'h00000003;
            5'd29:   val = 30'h00000001;
            default: val = 30'h0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/epg_div.sv
// Restoring serial divider of the ellipse point generator.
// Computes the low 16 quotient bits of (dividend * 2^16) / divisor, one bit a cycle.
// Depends on epg_pkg.
module epg_div
    import epg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    localparam int CNT_W = $clog2(DIV_BITS);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dvd_reg;
    logic [15:0]      quot_reg;

    logic [32:0] shifted;
    logic        fits;
    logic [32:0] diff;

    // The remainder stays below the divisor, so it always fits 32 bits.
    assign shifted = {rem_reg, dvd_reg[31]};
    assign fits    = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= dividend;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? diff[31:0] : shifted[31:0];
            dvd_reg  <= {dvd_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[14:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: rtl/epg_cordic.sv
// Iterative CORDIC rotator of the ellipse point generator.
// One shift-add rotation a cycle turns a 16-bit turn angle into rounded sine and cosine.
// Depends on epg_pkg for the angle table and gain.
module epg_cordic
    import epg_pkg::*;
#(
    parameter int TRIG_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [15:0]                 turn,
    output logic                        done,
    output logic signed [TRIG_BITS-1:0] sin_val,
    output logic signed [TRIG_BITS-1:0] cos_val
);

    localparam int SH = 31 - TRIG_BITS;
    localparam logic signed [33:0] RND  = 34'sd1 <<< (SH - 1);
    localparam logic signed [33:0] LIM  = (34'sd1 <<< (TRIG_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] NLIM = -LIM;

    logic                        run_reg;
    logic                        fin_reg;
    logic                        done_reg;
    logic [4:0]                  cnt_reg;
    logic                        neg_reg;
    logic signed [32:0]          x_reg;
    logic signed [32:0]          y_reg;
    logic signed [33:0]          z_reg;
    logic signed [TRIG_BITS-1:0] sin_reg;
    logic signed [TRIG_BITS-1:0] cos_reg;

    logic [31:0]        angle;
    logic [31:0]        quad;
    logic [31:0]        angle_adj;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [33:0] atan_step;
    logic signed [32:0] x_out;
    logic signed [32:0] y_out;

    // Round half up to TRIG_BITS bits and clip symmetrically.
    function automatic logic signed [TRIG_BITS-1:0] to_trig(input logic signed [32:0] v);
        logic signed [33:0] r;
        logic signed [TRIG_BITS-1:0] res;
        r = ($signed({v[32], v}) + RND) >>> SH;
        if (r > LIM)
            res = LIM[TRIG_BITS-1:0];
        else if (r < NLIM)
            res = NLIM[TRIG_BITS-1:0];
        else
            res = r[TRIG_BITS-1:0];
        return res;
    endfunction

    // Angles in the left half plane are rotated by half a turn and the result negated.
    assign angle     = {turn, 16'h0000};
    assign quad      = angle + 32'h40000000;
    assign angle_adj = quad[31] ? (angle ^ 32'h80000000) : angle;

    assign dx        = y_reg >>> cnt_reg;
    assign dy        = x_reg >>> cnt_reg;
    assign atan_step = $signed({4'b0000, cordic_atan(cnt_reg)});
    assign x_out     = neg_reg ? -x_reg : x_reg;
    assign y_out     = neg_reg ? -y_reg : y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(CORDIC_ITERS - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= $signed({1'b0, CORDIC_GAIN});
            y_reg   <= '0;
            z_reg   <= $signed({{2{angle_adj[31]}}, angle_adj});
            neg_reg <= quad[31];
        end
        else if (run_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_step;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_step;
            end
        end
        if (fin_reg)
        begin
            sin_reg <= to_trig(y_out);
            cos_reg <= to_trig(x_out);
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: rtl/ellipse_point_generator.sv
// Top level of the ellipse point generator: configuration registers, step accumulator,
// sequencer and the shared coordinate multiplier.
// Depends on epg_pkg, epg_div and epg_cordic.

// Each accepted request yields one point (x_coord, y_coord) on an axis-aligned ellipse,
// in signed Q16.8 and saturated to 24 bits. An advance request (action 0) takes the
// phase from step_position / steps_count and then moves step_position by stride: a sum
// above steps_count restarts at 0, a negative sum restarts at steps_count. A direct
// request (action 1) takes phase_turns as the fraction of a turn and leaves the step
// alone. The block works on one request at a time and holds in_ready low meanwhile.
// An advance request passes through the bit-serial phase divider (48 quotient bits and
// the handoff), the CORDIC rotator (30 rotations, the rounding step and the handoff),
// the two multiplications that share one multiplier and their adds, and then returns
// to idle, where the next request is taken. A direct request skips the divider. The
// finished point waits in an output register, so the next request is accepted while
// the previous point is still unclaimed; only the final write stalls until the output
// register is free.
// Configuration writes are always accepted (cfg_ready is tied high) and must only be
// issued while the block is idle. A write to steps_count below 6554 (0.1 in Q16.16)
// stores 100.0 instead, and writes to unknown indexes are ignored. TRIG_BITS sets the
// width of the rounded sine and cosine that multiply the radii.
module ellipse_point_generator
    import epg_pkg::*;
#(
    parameter int TRIG_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  in_req_t     in_req,

    output logic        out_valid,
    input  logic        out_ready,
    output out_res_t    out_res
);

    // Product and coordinate widths.
    localparam int PROD_W = TRIG_BITS + 24;
    localparam int SUM_W  = TRIG_BITS + 25;
    localparam logic signed [SUM_W-1:0] MUL_RND  = SUM_W'(1) <<< (TRIG_BITS - 2);
    localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(COORD_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LOW  = SUM_W'(COORD_MIN);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_MULX = 3'd3;
    localparam logic [2:0] ST_ADDX = 3'd4;
    localparam logic [2:0] ST_MULY = 3'd5;
    localparam logic [2:0] ST_ADDY = 3'd6;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;

    // Configuration registers.
    logic signed [23:0] center_x_reg;
    logic signed [23:0] center_y_reg;
    logic signed [23:0] radius_x_reg;
    logic signed [23:0] radius_y_reg;
    logic [31:0]        steps_count_reg;
    logic signed [31:0] stride_reg;

    logic [31:0] step_position_reg;
    logic [31:0] step_position_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    out_res_t    out_res_reg;
    logic signed [23:0] x_hold_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic        in_fire;
    logic        cfg_fire;
    logic        slot_free;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_quot;
    logic        cordic_start;
    logic        cordic_done;
    logic [15:0] phase;
    logic [15:0] turn;
    logic signed [TRIG_BITS-1:0] sin_val;
    logic signed [TRIG_BITS-1:0] cos_val;

    logic signed [33:0] step_sum;
    logic               mul_sel;
    logic signed [TRIG_BITS-1:0] mul_a;
    logic signed [23:0]          mul_b;
    logic signed [23:0]          center_sel;
    logic signed [SUM_W-1:0]     scaled;
    logic signed [SUM_W-1:0]     total;
    logic signed [23:0]          coord_sat;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= CENTER_X_RST;
            center_y_reg    <= CENTER_Y_RST;
            radius_x_reg    <= RADIUS_X_RST;
            radius_y_reg    <= RADIUS_Y_RST;
            steps_count_reg <= STEPS_DEFAULT;
            stride_reg      <= STRIDE_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_CENTER_X:    center_x_reg <= cfg_data[23:0];
                REG_CENTER_Y:    center_y_reg <= cfg_data[23:0];
                REG_RADIUS_X:    radius_x_reg <= cfg_data[23:0];
                REG_RADIUS_Y:    radius_y_reg <= cfg_data[23:0];
                REG_STEPS_COUNT: steps_count_reg <= (cfg_data < STEPS_MIN) ? STEPS_DEFAULT
                                                                            : cfg_data;
                REG_STRIDE:      stride_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Step accumulator: the old step feeds the divider, the wrapped sum is kept.
    assign step_sum = $signed({2'b00, step_position_reg})
                    + $signed({{2{stride_reg[31]}}, stride_reg});

    always_comb
    begin
        step_position_next = step_position_reg;
        if (in_fire && (in_req.action == ACT_ADVANCE))
        begin
            if (step_sum > $signed({2'b00, steps_count_reg}))
                step_position_next = '0;
            else if (step_sum[33])
                step_position_next = steps_count_reg;
            else
                step_position_next = step_sum[31:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        cordic_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_req.action == ACT_DIRECT)
                    begin
                        cordic_start = 1'b1;
                        state_next   = ST_ROT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (cordic_done)
                    state_next = ST_MULX;
            end
            ST_MULX: state_next = ST_ADDX;
            ST_ADDX: state_next = ST_MULY;
            ST_MULY: state_next = ST_ADDY;
            ST_ADDY:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The rotation angle is one turn minus the phase.
    assign phase = (state_reg == ST_IDLE) ? in_req.phase_turns : div_quot;
    assign turn  = 16'h0000 - phase;

    epg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (step_position_reg),
        .divisor  (steps_count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    epg_cordic #(
        .TRIG_BITS (TRIG_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .turn    (turn),
        .done    (cordic_done),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // One multiplier serves both axes: sine times radius_x, then cosine times radius_y.
    assign mul_sel    = (state_reg == ST_MULY);
    assign mul_a      = mul_sel ? cos_val : sin_val;
    assign mul_b      = mul_sel ? radius_y_reg : radius_x_reg;
    assign center_sel = (state_reg == ST_ADDY) ? center_y_reg : center_x_reg;

    // Round half up, add the center and clip to the 24-bit coordinate range.
    assign scaled = ($signed({prod_reg[PROD_W-1], prod_reg}) + MUL_RND) >>> (TRIG_BITS - 1);
    assign total  = scaled + $signed({{(SUM_W-24){center_sel[23]}}, center_sel});

    always_comb
    begin
        if (total > SAT_HIGH)
            coord_sat = SAT_HIGH[23:0];
        else if (total < SAT_LOW)
            coord_sat = SAT_LOW[23:0];
        else
            coord_sat = total[23:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if ((state_reg == ST_ADDY) && slot_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_position_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            step_position_reg <= step_position_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_MULX) || (state_reg == ST_MULY))
            prod_reg <= mul_a * mul_b;
        if (state_reg == ST_ADDX)
            x_hold_reg <= coord_sat;
        if ((state_reg == ST_ADDY) && slot_free)
        begin
            out_res_reg.x_coord <= x_hold_reg;
            out_res_reg.y_coord <= coord_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // The rotator finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_ROT))
        else $error("rotator finished outside the rotate state");

    // The step moves only when a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(step_position_reg))
        else $error("step position changed while busy");

    // A new point appears only from the final add of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_ADDY))
        else $error("result raised outside the final add");

endmodule

FILE: tb/sv/tb_ellipse_point_generator.sv
// Self-checking testbench of the ellipse point generator.
// It checks every point against a bit-exact predictor of the divider, CORDIC and scaling.
// Depends on epg_pkg and the ellipse_point_generator RTL.
module tb_ellipse_point_generator;
    import epg_pkg::*;

    // Width of the rounded sine and cosine; the block is built with the same value.
    localparam int TRIG_W = 16;

    // Register indexes that decode to nothing; writes to them must leave the block alone.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // Receiver hold-off used to fill the block until it stalls its input.
    localparam int LONG_HOLD = 500;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_CENTER_X;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_req_t     in_req    = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_res_t    out_res;

    ellipse_point_generator #(.TRIG_BITS(TRIG_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the configuration registers and the step accumulator. Coordinates and
    // radii are kept sign-extended so that the scaling arithmetic can run in 64 bits.
    longint      center_x_q, center_y_q, radius_x_q, radius_y_q, stride_q;
    logic [31:0] steps_q;
    logic [31:0] step_pos;

    // Arctangent of 2^-i in units of 2^-32 turn, one entry per CORDIC rotation.
    longint atan_turn [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    // Requests waiting for the driver, and points the block still owes us.
    in_req_t  request_queue [$];
    out_res_t point_queue [$];

    int requests_queued = 0;
    int points_seen     = 0;
    int reg_writes      = 0;
    int error_count     = 0;
    int advances_sent   = 0;
    int directs_sent    = 0;
    int hold_asked      = 0;
    int hold_served     = 0;
    bit tx_gaps_on      = 1'b1;
    bit rx_gaps_on      = 1'b1;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %0s", $time, msg);
        error_count++;
    endtask

    // Gap lengths: mostly none or short, now and then a long pause.
    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(12, 70);
    endfunction

    function automatic void reset_model();
        center_x_q = longint'($signed(CENTER_X_RST));
        center_y_q = longint'($signed(CENTER_Y_RST));
        radius_x_q = longint'($signed(RADIUS_X_RST));
        radius_y_q = longint'($signed(RADIUS_Y_RST));
        stride_q   = longint'($signed(STRIDE_RST));
        steps_q    = STEPS_DEFAULT;
        step_pos   = '0;
    endfunction

    // Register write as the block decodes it: the upper bits of the 24-bit registers are
    // dropped, a revolution length below 0.1 turns into 100.0, and spare indexes do nothing.
    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_CENTER_X:    center_x_q = longint'($signed(data[23:0]));
            REG_CENTER_Y:    center_y_q = longint'($signed(data[23:0]));
            REG_RADIUS_X:    radius_x_q = longint'($signed(data[23:0]));
            REG_RADIUS_Y:    radius_y_q = longint'($signed(data[23:0]));
            REG_STEPS_COUNT: steps_q    = (data < STEPS_MIN) ? STEPS_DEFAULT : data;
            REG_STRIDE:      stride_q   = longint'($signed(data));
            default:         ;
        endcase
    endfunction

    // Rounds a CORDIC output at scale 2^30 to TRIG_W bits with TRIG_W-1 fraction bits.
    // The arithmetic shift floors, so adding half an LSB first rounds half up.
    function automatic longint trig_round(input longint v);
        longint lim;
        longint r;
        lim = (longint'(1) << (TRIG_W - 1)) - 1;
        r   = (v + (longint'(1) << (30 - TRIG_W))) >>> (31 - TRIG_W);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    // Sine and cosine of a 16-bit turn angle. Angles in the left half plane are turned by
    // half a turn first and the results negated, so the rotator only sees +-90 degrees.
    function automatic void rotate_turn(input logic [15:0] turn,
                                        output longint sin_v, output longint cos_v);
        logic [31:0] a;
        logic [31:0] probe;
        bit          flip;
        longint      x, y, z, dx, dy;
        a     = {turn, 16'h0000};
        probe = a + 32'h4000_0000;
        flip  = probe[31];
        if (flip)
            a = a + 32'h8000_0000;
        z = longint'($signed(a));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sin_v = trig_round(y);
        cos_v = trig_round(x);
    endfunction

    function automatic logic [23:0] scale_coord(input longint center, input longint trig,
                                                input longint radius);
        longint v;
        v = center + ((trig * radius + (longint'(1) << (TRIG_W - 2))) >>> (TRIG_W - 1));
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[23:0];
    endfunction

    // Point for one accepted request. An advance request also moves the step accumulator,
    // so this must be called exactly once per request and in acceptance order.
    function automatic out_res_t next_point(input in_req_t req);
        logic [15:0] frac;
        logic [63:0] num;
        longint      nxt, sin_v, cos_v;
        out_res_t    pt;
        if (req.action == ACT_DIRECT)
            frac = req.phase_turns;
        else
        begin
            // A step beyond steps_count (after a shrink) simply wraps modulo one turn here.
            num  = {32'h0, step_pos} << 16;
            frac = 16'(num / {32'h0, steps_q});
            nxt  = longint'({32'h0, step_pos}) + stride_q;
            if (nxt > longint'({32'h0, steps_q}))
                nxt = 0;
            if (nxt < 0)
                nxt = longint'({32'h0, steps_q});
            step_pos = nxt[31:0];
        end
        rotate_turn(16'h0000 - frac, sin_v, cos_v);
        pt.x_coord = scale_coord(center_x_q, sin_v, radius_x_q);
        pt.y_coord = scale_coord(center_y_q, cos_v, radius_y_q);
        return pt;
    endfunction

    // Request driver. The next request is loaded only once the current one has been
    // taken, so valid and payload stay put while the block stalls. Each accepted
    // request is run through the predictor right at its acceptance edge.
    int tx_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                point_queue.push_back(next_point(in_req));
                if (in_req.action == ACT_DIRECT)
                    directs_sent++;
                else
                    advances_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (request_queue.size() > 0)
                begin
                    in_req   <= request_queue.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= pick_gap(tx_gaps_on);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Point monitor and receiver. Ready drops for random stretches, and once per request
    // from the stimulus it holds off for the LONG_HOLD hold-off so the block backs up.
    int rx_wait = 0;

    always @(posedge clk)
    begin
        out_res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                points_seen++;
                if (point_queue.size() == 0)
                    report_error($sformatf("point (%0d, %0d) with no request pending",
                                           out_res.x_coord, out_res.y_coord));
                else
                begin
                    want = point_queue.pop_front();
                    if (out_res.x_coord !== want.x_coord)
                        report_error($sformatf("x_coord %0d, expected %0d",
                                               out_res.x_coord, want.x_coord));
                    if (out_res.y_coord !== want.y_coord)
                        report_error($sformatf("y_coord %0d, expected %0d",
                                               out_res.y_coord, want.y_coord));
                end
            end
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait   <= rx_wait - 1;
            end
            else if (hold_served != hold_asked)
            begin
                out_ready   <= 1'b0;
                rx_wait     <= LONG_HOLD;
                hold_served <= hold_asked;
            end
            else if (rx_gaps_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                rx_wait   <= pick_gap(1'b1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic queue_request(input logic act, input logic [15:0] ph);
        in_req_t r;
        r.action      = act;
        r.phase_turns = ph;
        request_queue.push_back(r);
        requests_queued++;
    endtask

    // Advance requests carry random phase bits, which the block must ignore.
    task automatic queue_advances(input int n);
        repeat (n)
            queue_request(ACT_ADVANCE, 16'($urandom));
    endtask

    task automatic queue_random(input int n);
        logic [15:0] ph;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 72)
                queue_request(ACT_ADVANCE, 16'($urandom));
            else
            begin
                case ($urandom_range(0, 9))
                    0:       ph = 16'h0000;
                    1:       ph = 16'hFFFF;
                    2:       ph = 16'h4000;
                    3:       ph = 16'hC000;
                    default: ph = 16'($urandom);
                endcase
                queue_request(ACT_DIRECT, ph);
            end
        end
    endtask

    // Blocks until every queued request has produced its point.
    task automatic wait_drained();
        while (points_seen < requests_queued)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord();
        longint v;
        case ($urandom_range(0, 7))
            0:       return 32'h007F_FFFF;
            1:       return 32'h0080_0000;
            2:       return 32'h0000_0000;
            3:       return $urandom;
            default:
            begin
                v = longint'($urandom_range(0, 262143)) - 131072;
                return v[31:0];
            end
        endcase
    endfunction

    // New random setting. The stride is usually a fraction of the revolution so the
    // accumulator wraps within one phase, at the top or bottom by the stride's sign; extremes show up now and then.
    task automatic random_config();
        logic [31:0] steps_val, eff, mag, strd;
        write_reg(REG_CENTER_X, pick_coord());
        write_reg(REG_CENTER_Y, pick_coord());
        write_reg(REG_RADIUS_X, pick_coord());
        write_reg(REG_RADIUS_Y, pick_coord());
        case ($urandom_range(0, 7))
            0:       steps_val = $urandom_range(0, 6553);
            1:       steps_val = STEPS_MIN;
            2:       steps_val = $urandom;
            3:       steps_val = 32'hFFFF_FFFF;
            default: steps_val = $urandom_range(6554, 13107200);
        endcase
        write_reg(REG_STEPS_COUNT, steps_val);
        eff = (steps_val < STEPS_MIN) ? STEPS_DEFAULT : steps_val;
        case ($urandom_range(0, 9))
            0:       strd = 32'h7FFF_FFFF;
            1:       strd = 32'h8000_0000;
            2:       strd = $urandom;
            default:
            begin
                mag  = eff / $urandom_range(2, 40) + $urandom_range(0, 65535);
                strd = $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
        write_reg(REG_STRIDE, strd);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    endtask

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: a few orbit steps, the quarter turns and both ends of the
        // direct phase range.
        queue_advances(3);
        queue_request(ACT_DIRECT, 16'h0000);
        queue_request(ACT_DIRECT, 16'h4000);
        queue_request(ACT_DIRECT, 16'h8000);
        queue_request(ACT_DIRECT, 16'hC000);
        queue_request(ACT_DIRECT, 16'hFFFF);
        queue_request(ACT_DIRECT, 16'h0001);
        queue_request(ACT_ADVANCE, 16'hFFFF);
        wait_drained();

        // Extreme centers and radii so both coordinates saturate, a too-small revolution
        // length that must turn into 100.0, a negative stride that wraps to the top, and
        // writes to the spare indexes that must change nothing.
        write_reg(REG_CENTER_X, 32'h007F_FFFF);
        write_reg(REG_CENTER_Y, 32'h0080_0000);
        write_reg(REG_RADIUS_X, 32'h007F_FFFF);
        write_reg(REG_RADIUS_Y, 32'h0080_0000);
        write_reg(REG_STEPS_COUNT, 32'd100);
        write_reg(REG_STRIDE, 32'hFFFC_8000);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        queue_advances(2);
        queue_request(ACT_DIRECT, 16'h4000);
        queue_request(ACT_DIRECT, 16'hC000);
        wait_drained();

        // Smallest legal revolution with the largest stride: every advance overshoots.
        // Register data with all upper bits set checks the masking of the 24-bit fields.
        write_reg(REG_CENTER_X, 32'h0000_0000);
        write_reg(REG_CENTER_Y, 32'hFF00_0000);
        write_reg(REG_RADIUS_X, 32'hFFFF_FFFF);
        write_reg(REG_RADIUS_Y, 32'h0012_3456);
        write_reg(REG_STEPS_COUNT, STEPS_MIN);
        write_reg(REG_STRIDE, 32'h7FFF_FFFF);
        queue_advances(2);
        wait_drained();

        // Walk far up a huge revolution, then shrink it so the step sits beyond the end.
        write_reg(REG_STEPS_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_STRIDE, 32'h4000_0000);
        queue_advances(3);
        wait_drained();
        write_reg(REG_STEPS_COUNT, STEPS_MIN);
        queue_advances(2);
        wait_drained();

        // Most negative stride on the largest revolution: wrap to the top and back down.
        write_reg(REG_STEPS_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_STRIDE, 32'h8000_0000);
        queue_advances(2);
        wait_drained();

        // Random settings with mostly orbit advances. Idling on either side is switched
        // off in some phases; in one phase the receiver holds off while the sender keeps
        // pushing requests, which backs the block up until it stalls its input.
        for (int ph = 0; ph < 9; ph++)
        begin
            random_config();
            tx_gaps_on = (ph % 3) != 0;
            rx_gaps_on = (ph % 4) != 1;
            if (ph == 2)
            begin
                tx_gaps_on = 1'b0;
                hold_asked++;
            end
            queue_random(50);
            wait_drained();
        end

        // Give the block time to emit anything it should not, then look for leftovers.
        repeat (120) @(posedge clk);
        if (point_queue.size() != 0)
            report_error($sformatf("%0d points never arrived", point_queue.size()));

        $display("Run covered %0d requests (%0d advance, %0d direct) and %0d points",
                 requests_queued, advances_sent, directs_sent, points_seen);
        $display("across %0d register writes, with %0d errors", reg_writes, error_count);
        if (error_count == 0)
            $display("tb_ellipse_point_generator: clean");
        else
            $display("tb_ellipse_point_generator: errors");
        $finish;
    end

    // Watchdog: a hung handshake or a missing point ends the run here.
    initial
    begin
        #5000000;
        $display("Timeout with %0d of %0d points seen", points_seen, requests_queued);
        $display("tb_ellipse_point_generator: errors");
        $finish;
    end

endmodule
